>>> src/tqps_pkg.sv
package tqps_pkg;

   localparam int SLOTS_DEFAULT     = 64;
   localparam int PID_WIDTH_DEFAULT = 16;
   localparam int RANK_W            = 55;

   typedef enum logic [2:0] {
      OP_WRITE        = 3'd0,
      OP_SET_STATE    = 3'd1,
      OP_CHANGE_QUEUE = 3'd2,
      OP_WEIGHTS_PID  = 3'd3,
      OP_WEIGHTS_ALL  = 3'd4,
      OP_AGE          = 3'd5,
      OP_SCHEDULE     = 3'd6
   } op_type;

   // unassigned operation code, answered with no effect
   localparam logic [2:0] OP_UNDEFINED = 3'd7;

   localparam logic [2:0] RS_UNUSED     = 3'd0;
   localparam logic [2:0] RS_SLEEPING   = 3'd2;
   localparam logic [2:0] RS_RUNNABLE   = 3'd3;
   localparam logic [2:0] RS_RUNNING    = 3'd4;
   localparam logic [2:0] RS_RESERVED_A = 3'd6;
   localparam logic [2:0] RS_RESERVED_B = 3'd7;

   localparam logic [1:0] QUEUE_UNSET = 2'd0;
   localparam logic [1:0] QUEUE_RR    = 2'd1;
   localparam logic [1:0] QUEUE_LCFS  = 2'd2;
   localparam logic [1:0] QUEUE_BJF   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISS    = 2'd1;
   localparam logic [1:0] STATUS_BAD_PID = 2'd2;

   localparam logic [1:0] POLICY_RR   = 2'd0;
   localparam logic [1:0] POLICY_LCFS = 2'd1;
   localparam logic [1:0] POLICY_BJF  = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_TGT_READ,
      S_TGT_DATA
   } state_type;

   // slot entry without the pid, which follows the pid width parameter
   typedef struct packed {
      logic [2:0]  run_state;
      logic [1:0]  queue;
      logic [31:0] creation;
      logic [31:0] arrival;
      logic [31:0] ran_at;
      logic [7:0]  prio;
      logic [31:0] size;
      logic [15:0] dispatches;
      logic [63:0] weights;
   } entry_body_type;

endpackage

>>> src/three_queue_process_scheduler_top.sv
// channel   ports                      handshake
// request   start, busy, req_*         transfer when start high and busy low
// response  rsp_valid, rsp_*           one-cycle strobe, no back pressure
// config    csr_we, csr_wdata          write when csr_we high, any time
//
// write slot answers the cycle after the transfer, set run state from S_TGT_DATA
// weight sweeps, aging and pid misses answer as the scan ends, a found pid from S_TGT_DATA,
// schedule likewise after the rank pipeline drains: one memory read per slot, a rank
// pipeline, write-back; after reset a clearing pass zeroes every slot while busy is high
// responses cannot be stalled; busy is low by the time the response is out
module three_queue_process_scheduler_top #(
   parameter int SLOTS     = tqps_pkg::SLOTS_DEFAULT,
   parameter int PID_WIDTH = tqps_pkg::PID_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_operation,
   input  logic [5:0]           req_slot,
   input  logic [PID_WIDTH-1:0] req_pid,
   input  logic [2:0]           req_run_state,
   input  logic [1:0]           req_queue,
   input  logic [31:0]          req_time_value,
   input  logic [7:0]           req_priority_req,
   input  logic [31:0]          req_process_size,
   input  logic [15:0]          req_weight_priority,
   input  logic [15:0]          req_weight_arrival,
   input  logic [15:0]          req_weight_executed,
   input  logic [15:0]          req_weight_size,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [5:0]           rsp_chosen_slot,
   output logic [PID_WIDTH-1:0] rsp_chosen_pid,
   output logic [1:0]           rsp_prev_queue,
   output logic [1:0]           rsp_policy_used,
   input  logic                 csr_we,
   input  logic [31:0]          csr_wdata
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int BODY_W = $bits(tqps_pkg::entry_body_type);
   localparam int WORD_W = PID_WIDTH + BODY_W;

   tqps_pkg::state_type state_ff, state_in;

   logic [IDX_W:0]   rd_cnt_ff, rd_cnt_in;
   logic             rdv_ff, rdv_in;
   logic [IDX_W-1:0] a1_ff, a1_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [31:0]      aging_ff;
   logic [IDX_W-1:0] rr_last_ff, rr_last_in;

   logic [2:0]           op_ff, op_in;
   logic [PID_WIDTH-1:0] pid_ff, pid_in;
   logic [2:0]           rs_ff, rs_in;
   logic [1:0]           q_ff, q_in;
   logic [31:0]          now_ff, now_in;
   logic [63:0]          wts_ff, wts_in;

   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            tgt_ff, tgt_in;
   logic                        rra_found_ff, rra_found_in;
   logic [IDX_W-1:0]            rra_ff, rra_in;
   logic                        rrb_found_ff, rrb_found_in;
   logic [IDX_W-1:0]            rrb_ff, rrb_in;
   logic                        lc_found_ff, lc_found_in;
   logic [IDX_W-1:0]            lc_ff, lc_in;
   logic [31:0]                 lc_best_ff, lc_best_in;
   logic                        bj_found_ff, bj_found_in;
   logic [IDX_W-1:0]            bj_ff, bj_in;
   logic [tqps_pkg::RANK_W-1:0] bj_best_ff, bj_best_in;
   logic [1:0]                  pol_ff, pol_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [5:0]           rsp_slot_ff, rsp_slot_in;
   logic [PID_WIDTH-1:0] rsp_pid_ff, rsp_pid_in;
   logic [1:0]           rsp_oldq_ff, rsp_oldq_in;
   logic [1:0]           rsp_pol_ff, rsp_pol_in;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic [IDX_W-1:0]     mem_raddr;
   logic [WORD_W-1:0]    mem_rdata;

   tqps_pkg::entry_body_type rd_body, wr_body;
   logic [PID_WIDTH-1:0]     rd_pid;
   logic                     accept, slot_ok, scan_done;
   logic [IDX_W-1:0]         slot_idx;

   logic                        rk_in_valid, rk_valid, rk_busy;
   logic [IDX_W-1:0]            rk_idx;
   logic [tqps_pkg::RANK_W-1:0] rk_rank;

   tqps_mem #(
      .DEPTH (SLOTS),
      .WIDTH (WORD_W),
      .AW    (IDX_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rd_pid  = mem_rdata[WORD_W-1:BODY_W];
   assign rd_body = tqps_pkg::entry_body_type'(mem_rdata[BODY_W-1:0]);

   assign rk_in_valid = (state_ff == tqps_pkg::S_SCAN) && rdv_ff
                        && (op_ff == tqps_pkg::OP_SCHEDULE)
                        && (rd_body.run_state == tqps_pkg::RS_RUNNABLE)
                        && (rd_body.queue == tqps_pkg::QUEUE_BJF);

   tqps_rank #(
      .AW (IDX_W)
   ) u_rank (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rk_in_valid),
      .in_idx    (a1_ff),
      .in_body   (rd_body),
      .out_valid (rk_valid),
      .out_idx   (rk_idx),
      .out_rank  (rk_rank),
      .busy      (rk_busy)
   );

   assign accept    = start && (state_ff == tqps_pkg::S_IDLE);
   assign slot_ok   = {26'd0, req_slot} < 32'(SLOTS);
   assign slot_idx  = IDX_W'(req_slot);
   assign scan_done = (rd_cnt_ff == (IDX_W+1)'(SLOTS)) && !rdv_ff && !rk_busy;

   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      rdv_in       = 1'b0;
      a1_in        = a1_ff;
      clr_cnt_in   = clr_cnt_ff;
      rr_last_in   = rr_last_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      rs_in        = rs_ff;
      q_in         = q_ff;
      now_in       = now_ff;
      wts_in       = wts_ff;
      found_in     = found_ff;
      tgt_in       = tgt_ff;
      rra_found_in = rra_found_ff;
      rra_in       = rra_ff;
      rrb_found_in = rrb_found_ff;
      rrb_in       = rrb_ff;
      lc_found_in  = lc_found_ff;
      lc_in        = lc_ff;
      lc_best_in   = lc_best_ff;
      bj_found_in  = bj_found_ff;
      bj_in        = bj_ff;
      bj_best_in   = bj_best_ff;
      pol_in       = pol_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = tqps_pkg::STATUS_OK;
      rsp_slot_in   = '0;
      rsp_pid_in    = '0;
      rsp_oldq_in   = '0;
      rsp_pol_in    = tqps_pkg::POLICY_RR;
      mem_we    = 1'b0;
      mem_waddr = a1_ff;
      mem_raddr = rd_cnt_ff[IDX_W-1:0];
      wr_body   = rd_body;
      mem_wdata = {rd_pid, rd_body};

      unique case (state_ff)
         tqps_pkg::S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(SLOTS - 1)) begin
               state_in = tqps_pkg::S_IDLE;
            end
         end

         tqps_pkg::S_IDLE: begin
            if (accept) begin
               op_in  = req_operation;
               pid_in = req_pid;
               rs_in  = req_run_state;
               q_in   = req_queue;
               now_in = req_time_value;
               wts_in = {req_weight_size, req_weight_executed, req_weight_arrival,
                         req_weight_priority};
               found_in     = 1'b0;
               rra_found_in = 1'b0;
               rrb_found_in = 1'b0;
               lc_found_in  = 1'b0;
               bj_found_in  = 1'b0;
               rd_cnt_in    = '0;
               unique case (req_operation)
                  tqps_pkg::OP_WRITE: begin
                     rsp_valid_in = 1'b1;
                     if (slot_ok) begin
                        wr_body.run_state  = req_run_state;
                        wr_body.queue      = req_queue;
                        wr_body.creation   = req_time_value;
                        wr_body.arrival    = req_time_value;
                        wr_body.ran_at     = req_time_value;
                        wr_body.prio       = req_priority_req;
                        wr_body.size       = req_process_size;
                        wr_body.dispatches = '0;
                        wr_body.weights    = wts_in;
                        mem_we      = 1'b1;
                        mem_waddr   = slot_idx;
                        mem_wdata   = {req_pid, wr_body};
                        rsp_slot_in = req_slot;
                        rsp_pid_in  = req_pid;
                     end else begin
                        rsp_status_in = tqps_pkg::STATUS_MISS;
                     end
                  end
                  tqps_pkg::OP_SET_STATE: begin
                     if (slot_ok) begin
                        mem_raddr = slot_idx;
                        tgt_in    = slot_idx;
                        state_in  = tqps_pkg::S_TGT_DATA;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = tqps_pkg::STATUS_MISS;
                     end
                  end
                  tqps_pkg::OP_CHANGE_QUEUE: begin
                     state_in = tqps_pkg::S_SCAN;
                     // unset queue: pid 1 goes round robin, higher pids lcfs
                     if (req_queue == tqps_pkg::QUEUE_UNSET) begin
                        if (req_pid == PID_WIDTH'(1)) begin
                           q_in = tqps_pkg::QUEUE_RR;
                        end else if (req_pid != '0) begin
                           q_in = tqps_pkg::QUEUE_LCFS;
                        end else begin
                           state_in      = tqps_pkg::S_IDLE;
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = tqps_pkg::STATUS_BAD_PID;
                        end
                     end
                  end
                  tqps_pkg::OP_WEIGHTS_PID, tqps_pkg::OP_WEIGHTS_ALL,
                  tqps_pkg::OP_AGE, tqps_pkg::OP_SCHEDULE: begin
                     state_in = tqps_pkg::S_SCAN;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         tqps_pkg::S_SCAN: begin
            if (rd_cnt_ff < (IDX_W+1)'(SLOTS)) begin
               mem_raddr = rd_cnt_ff[IDX_W-1:0];
               rdv_in    = 1'b1;
               a1_in     = rd_cnt_ff[IDX_W-1:0];
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (rdv_ff) begin
               case (op_ff) inside
                  tqps_pkg::OP_CHANGE_QUEUE, tqps_pkg::OP_WEIGHTS_PID: begin
                     if (!found_ff && rd_pid == pid_ff) begin
                        found_in = 1'b1;
                        tgt_in   = a1_ff;
                     end
                  end
                  tqps_pkg::OP_WEIGHTS_ALL: begin
                     wr_body.weights = wts_ff;
                     mem_we    = 1'b1;
                     mem_wdata = {rd_pid, wr_body};
                  end
                  tqps_pkg::OP_AGE: begin
                     if (rd_body.run_state == tqps_pkg::RS_RUNNABLE
                         && rd_body.queue != tqps_pkg::QUEUE_RR
                         && (now_ff - rd_body.ran_at) > aging_ff) begin
                        wr_body.queue = tqps_pkg::QUEUE_RR;
                        mem_we    = 1'b1;
                        mem_wdata = {rd_pid, wr_body};
                     end
                  end
                  tqps_pkg::OP_SCHEDULE: begin
                     if (rd_body.run_state == tqps_pkg::RS_RUNNABLE) begin
                        if (rd_body.queue == tqps_pkg::QUEUE_RR) begin
                           // lowest ready slot overall, and lowest after the last pick
                           if (!rra_found_ff) begin
                              rra_found_in = 1'b1;
                              rra_in       = a1_ff;
                           end
                           if (!rrb_found_ff && a1_ff > rr_last_ff) begin
                              rrb_found_in = 1'b1;
                              rrb_in       = a1_ff;
                           end
                        end
                        if (rd_body.queue == tqps_pkg::QUEUE_LCFS
                            && (!lc_found_ff || rd_body.creation > lc_best_ff)) begin
                           lc_found_in = 1'b1;
                           lc_in       = a1_ff;
                           lc_best_in  = rd_body.creation;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (rk_valid && (!bj_found_ff || rk_rank < bj_best_ff)) begin
               bj_found_in = 1'b1;
               bj_in       = rk_idx;
               bj_best_in  = rk_rank;
            end
            if (scan_done) begin
               state_in = tqps_pkg::S_IDLE;
               case (op_ff) inside
                  tqps_pkg::OP_CHANGE_QUEUE, tqps_pkg::OP_WEIGHTS_PID: begin
                     if (found_ff) begin
                        state_in = tqps_pkg::S_TGT_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = tqps_pkg::STATUS_MISS;
                     end
                  end
                  tqps_pkg::OP_SCHEDULE: begin
                     state_in = tqps_pkg::S_TGT_READ;
                     if (rrb_found_ff) begin
                        tgt_in = rrb_ff;
                        pol_in = tqps_pkg::POLICY_RR;
                     end else if (rra_found_ff) begin
                        tgt_in = rra_ff;
                        pol_in = tqps_pkg::POLICY_RR;
                     end else if (lc_found_ff) begin
                        tgt_in = lc_ff;
                        pol_in = tqps_pkg::POLICY_LCFS;
                     end else if (bj_found_ff) begin
                        tgt_in = bj_ff;
                        pol_in = tqps_pkg::POLICY_BJF;
                     end else begin
                        state_in      = tqps_pkg::S_IDLE;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = tqps_pkg::STATUS_MISS;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         tqps_pkg::S_TGT_READ: begin
            mem_raddr = tgt_ff;
            state_in  = tqps_pkg::S_TGT_DATA;
         end

         tqps_pkg::S_TGT_DATA: begin
            state_in     = tqps_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_slot_in  = 6'(tgt_ff);
            mem_waddr    = tgt_ff;
            case (op_ff)
               tqps_pkg::OP_SET_STATE: begin
                  wr_body.run_state = rs_ff;
                  mem_we     = 1'b1;
                  rsp_pid_in = rd_pid;
               end
               tqps_pkg::OP_CHANGE_QUEUE: begin
                  wr_body.queue = q_ff;
                  mem_we      = 1'b1;
                  rsp_pid_in  = pid_ff;
                  rsp_oldq_in = rd_body.queue;
               end
               tqps_pkg::OP_WEIGHTS_PID: begin
                  wr_body.weights = wts_ff;
                  mem_we     = 1'b1;
                  rsp_pid_in = pid_ff;
               end
               tqps_pkg::OP_SCHEDULE: begin
                  wr_body.run_state = tqps_pkg::RS_RUNNING;
                  wr_body.ran_at    = now_ff;
                  if (rd_body.dispatches != 16'hFFFF) begin
                     wr_body.dispatches = rd_body.dispatches + 16'd1;
                  end
                  mem_we     = 1'b1;
                  rsp_pid_in = rd_pid;
                  rsp_pol_in = pol_ff;
                  if (pol_ff == tqps_pkg::POLICY_RR) begin
                     rr_last_in = tgt_ff;
                  end
               end
               default: begin
               end
            endcase
            mem_wdata = {rd_pid, wr_body};
         end

         default: begin
            state_in = tqps_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tqps_pkg::S_CLEAR;
         rd_cnt_ff    <= '0;
         rdv_ff       <= 1'b0;
         clr_cnt_ff   <= '0;
         aging_ff     <= 32'd8000;
         rr_last_ff   <= IDX_W'(SLOTS - 1);
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         rra_found_ff <= 1'b0;
         rrb_found_ff <= 1'b0;
         lc_found_ff  <= 1'b0;
         bj_found_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         rdv_ff       <= rdv_in;
         clr_cnt_ff   <= clr_cnt_in;
         rr_last_ff   <= rr_last_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         rra_found_ff <= rra_found_in;
         rrb_found_ff <= rrb_found_in;
         lc_found_ff  <= lc_found_in;
         bj_found_ff  <= bj_found_in;
         if (csr_we) begin
            aging_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      a1_ff         <= a1_in;
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      rs_ff         <= rs_in;
      q_ff          <= q_in;
      now_ff        <= now_in;
      wts_ff        <= wts_in;
      tgt_ff        <= tgt_in;
      rra_ff        <= rra_in;
      rrb_ff        <= rrb_in;
      lc_ff         <= lc_in;
      lc_best_ff    <= lc_best_in;
      bj_ff         <= bj_in;
      bj_best_ff    <= bj_best_in;
      pol_ff        <= pol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_oldq_ff   <= rsp_oldq_in;
      rsp_pol_ff    <= rsp_pol_in;
   end

   assign busy            = (state_ff != tqps_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_chosen_pid  = rsp_pid_ff;
   assign rsp_prev_queue  = rsp_oldq_ff;
   assign rsp_policy_used = rsp_pol_ff;

   // scan reads must be drained before the target entry is rewritten
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tqps_pkg::S_TGT_DATA) |-> (!rdv_ff && !rk_busy))
      else $error("target update overlaps scan reads");

   a_rr_last_range: assert property (@(posedge clock) disable iff (reset)
      rr_last_ff <= IDX_W'(SLOTS - 1))
      else $error("round robin pointer out of range");

   a_tgt_from_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tqps_pkg::S_TGT_READ) |-> ($past(state_ff) == tqps_pkg::S_SCAN))
      else $error("target read without a finished scan");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tqps_pkg::S_CLEAR) |=> !rsp_valid_ff)
      else $error("response during clearing pass");

endmodule

>>> src/tqps_mem.sv
module tqps_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/tqps_rank.sv
module tqps_rank #(
   parameter int AW = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [AW-1:0]              in_idx,
   input  tqps_pkg::entry_body_type   in_body,
   output logic                       out_valid,
   output logic [AW-1:0]              out_idx,
   output logic [tqps_pkg::RANK_W-1:0] out_rank,
   output logic                       busy
);

   logic                        v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]               idx1_ff, idx2_ff, idx3_ff;
   logic [23:0]                 pp_ff;
   logic [47:0]                 pa_ff;
   logic [31:0]                 pd_ff;
   logic [47:0]                 ps_ff;
   logic [49:0]                 sum_ff;
   logic [31:0]                 pd2_ff;
   logic [tqps_pkg::RANK_W-1:0] rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // products, then the sum of the times-ten terms, then the final rank
   always_ff @(posedge clock) begin
      idx1_ff <= in_idx;
      pp_ff   <= in_body.prio * in_body.weights[15:0];
      pa_ff   <= in_body.arrival * in_body.weights[31:16];
      pd_ff   <= in_body.dispatches * in_body.weights[47:32];
      ps_ff   <= in_body.size * in_body.weights[63:48];
      idx2_ff <= idx1_ff;
      sum_ff  <= 50'(pp_ff) + 50'(pa_ff) + 50'(ps_ff);
      pd2_ff  <= pd_ff;
      idx3_ff <= idx2_ff;
      rank_ff <= tqps_pkg::RANK_W'({sum_ff, 3'b000}) + tqps_pkg::RANK_W'({sum_ff, 1'b0})
               + tqps_pkg::RANK_W'(pd2_ff);
   end

   assign out_valid = v3_ff;
   assign out_idx   = idx3_ff;
   assign out_rank  = rank_ff;
   assign busy      = v1_ff | v2_ff | v3_ff;

endmodule
